/* design/bi24_pkg.sv */
// Shared types and constants for the 24-column block bit interleaver.
package bi24_pkg;

    // Number of columns in the interleaver matrix
    localparam int unsigned COLS = 24;

    // Field widths fixed by the interface
    localparam int unsigned FB_W    = 10;   // frame_bits, address, indexes
    localparam int unsigned STR_W   = 4;    // stride
    localparam int unsigned COL_W   = 5;    // column count and remainder
    localparam int unsigned Q_W     = 6;    // frame_bits / 24 (at most 42)
    localparam int unsigned PROD_W  = 14;   // stride * row or stride * (q + 1)
    localparam int unsigned CFG_A_W = 2;    // config register index

    // Reciprocal for frame_bits / 24: (x * 2731) >> 16 is exact for x < 1024
    localparam int unsigned RECIP_W  = 12;
    localparam int unsigned RECIP_SH = 16;
    localparam logic [RECIP_W-1:0] RECIP_24 = 12'd2731;

    // Request codes
    typedef enum logic [1:0] {
        REQ_LINEAR = 2'd0,
        REQ_DIRECT = 2'd1,
        REQ_START  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // Config register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_FRAME_BITS = 2'd0,
        CFG_STRIDE     = 2'd1,
        CFG_DIRECTION  = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,   // waiting for a request
        ST_EXEC = 2'd1,   // store access and counter update
        ST_ADV  = 2'd2,   // offset reduction, read data returns
        ST_RESP = 2'd3    // hand the result to the output register
    } t_state;

endpackage

/* design/block_bit_interleaver_24col.sv */
// Top level of the 24-column block bit interleaver: sequencer, address generator, store.
//
// Requests arrive on i_in_valid / o_in_ready with a request type, a data bit, an
// address and a write enable. A start request sets the base address and clears
// the column, row, offset and bit counters. A linear request writes (interleave)
// or reads (de-interleave) the store at the generated 24-column address; a direct
// request reads or writes any address. Every request gives exactly one result on
// o_out_valid / i_out_ready.
// Config registers are written over i_cfg_valid / o_cfg_ready with i_cfg_index and
// i_cfg_data; the channel is always ready, and writes belong between frames while
// no request is in flight.
// A request is taken only while the sequencer is idle. It then passes through
// the store access, the registered read and offset reduction, and the result
// load; once its result is loaded the sequencer is idle again and can take the
// next request, so a new request is not taken before the last result is loaded.
// Reset clears the counters, base address and output valid and sets frame_bits=1,
// stride=1, direction=0; store contents are unknown until written. While the
// receiver stalls, the result waits in the output register and the next request
// is processed up to its result hand-off.
module block_bit_interleaver_24col
    import bi24_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic               i_data_bit,
    input  logic [FB_W-1:0]    i_address,
    input  logic               i_write_enable,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_read_bit,
    output logic [FB_W-1:0]    o_linear_index,
    output logic [FB_W-1:0]    o_store_address,
    output logic               o_frame_done,
    output logic               o_out_of_frame,
    // config channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_A_W-1:0] i_cfg_index,
    input  logic [FB_W-1:0]    i_cfg_data
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int MW    = 24;   // holds STORE_DEPTH << 7 for the largest depth
    localparam int NSTEP = 8;    // quotient below 256 for every reduced value

    // Reduce a value modulo the store depth by binary compare-subtract
    function automatic logic [AW-1:0] f_mod_depth(input logic [MW-1:0] v);
        logic [MW-1:0] t;
        t = v;
        for (int k = NSTEP - 1; k >= 0; k--) begin
            if (t >= (MW'(STORE_DEPTH) << k)) begin
                t = t - (MW'(STORE_DEPTH) << k);
            end
        end
        return t[AW-1:0];
    endfunction

    // Low 10 bits of a store address for the result
    function automatic logic [FB_W-1:0] f_sa(input logic [AW-1:0] a);
        logic [MW-1:0] w;
        w = MW'(a);
        return w[FB_W-1:0];
    endfunction

    t_state r_state, n_state;

    // config registers and derived q, r
    logic [FB_W-1:0]  r_frame_bits;
    logic [STR_W-1:0] r_stride;
    logic             r_direction;
    logic [Q_W-1:0]   r_q;
    logic [COL_W-1:0] r_r;

    // address generator state
    logic [COL_W-1:0] r_col, n_col;
    logic [FB_W-1:0]  r_row, n_row;
    logic [AW-1:0]    r_offset, n_offset;
    logic [FB_W-1:0]  r_bitpos, n_bitpos;
    logic [AW-1:0]    r_base, n_base;

    // captured request
    t_req             r_req;
    logic             r_dbit;
    logic [FB_W-1:0]  r_addr;
    logic             r_we;

    // per-request result and offset step
    logic             r_res_rd, n_res_rd;
    logic [FB_W-1:0]  r_res_li, n_res_li;
    logic [FB_W-1:0]  r_res_sa, n_res_sa;
    logic             r_res_fd, n_res_fd;
    logic             r_res_oof, n_res_oof;
    logic             r_adv, n_adv;
    logic             r_wrap, n_wrap;
    logic [PROD_W-1:0] r_prod, n_prod;

    // output register
    logic             r_out_valid;
    logic             r_out_rb;
    logic [FB_W-1:0]  r_out_li;
    logic [FB_W-1:0]  r_out_sa;
    logic             r_out_fd;
    logic             r_out_oof;

    // store port
    logic             ram_we, ram_re, ram_wdata, ram_rdata;
    logic [AW-1:0]    ram_addr;

    logic             in_xfer, out_free, cfg_xfer;
    logic [21:0]      q_prod;
    logic [Q_W-1:0]   q_val;
    logic [AW-1:0]    lin_addr, dir_addr;
    logic [COL_W-1:0] col_inc;
    logic [FB_W-1:0]  row_inc, bitpos_inc, mul_opnd;
    logic             in_frame;

    assign in_xfer  = i_in_valid & o_in_ready;
    assign out_free = ~r_out_valid | i_out_ready;
    assign cfg_xfer = i_cfg_valid & o_cfg_ready;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bits <= FB_W'(1);
            r_stride     <= STR_W'(1);
            r_direction  <= 1'b0;
        end else if (cfg_xfer) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_BITS: r_frame_bits <= i_cfg_data;
                CFG_STRIDE:     r_stride     <= i_cfg_data[STR_W-1:0];
                CFG_DIRECTION:  r_direction  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // q = frame_bits / 24 and r = frame_bits % 24, registered from the frame_bits register
    assign q_prod = 22'(r_frame_bits) * 22'(RECIP_24);
    assign q_val  = q_prod[RECIP_SH +: Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
            r_r <= COL_W'(1);
        end else begin
            r_q <= q_val;
            r_r <= COL_W'(r_frame_bits - {q_val, 4'b0} - {1'b0, q_val, 3'b0});
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_xfer) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_ADV;
            ST_ADV:  n_state = ST_RESP;
            ST_RESP: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // address generation and store access
    assign lin_addr   = f_mod_depth(MW'(r_base) + MW'(r_offset));
    assign dir_addr   = f_mod_depth(MW'(r_addr));
    assign col_inc    = r_col + COL_W'(1);
    assign row_inc    = r_row + FB_W'(1);
    assign bitpos_inc = r_bitpos + FB_W'(1);
    assign in_frame   = (r_bitpos < r_frame_bits);
    assign mul_opnd   = (col_inc == COL_W'(COLS)) ? row_inc
                      : FB_W'(r_q) + FB_W'((col_inc > r_r) ? 1'b0 : 1'b1);

    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = lin_addr;
        ram_wdata  = r_dbit;
        n_col      = r_col;
        n_row      = r_row;
        n_offset   = r_offset;
        n_bitpos   = r_bitpos;
        n_base     = r_base;
        n_res_rd   = 1'b0;
        n_res_li   = '0;
        n_res_sa   = '0;
        n_res_fd   = 1'b0;
        n_res_oof  = 1'b0;
        n_adv      = 1'b0;
        n_wrap     = r_wrap;
        n_prod     = r_prod;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_EXEC: begin
                case (r_req)
                    REQ_START: begin
                        n_base   = dir_addr;
                        n_col    = '0;
                        n_row    = '0;
                        n_offset = '0;
                        n_bitpos = '0;
                        n_res_sa = f_sa(dir_addr);
                    end
                    REQ_DIRECT: begin
                        ram_addr = dir_addr;
                        ram_we   = r_we;
                        ram_re   = ~r_we;
                        n_res_rd = ~r_we;
                        n_res_sa = f_sa(dir_addr);
                    end
                    REQ_LINEAR: begin
                        if (in_frame) begin
                            ram_we   = ~r_direction;
                            ram_re   = r_direction;
                            n_res_rd = r_direction;
                            n_res_li = r_bitpos;
                            n_res_sa = f_sa(lin_addr);
                            n_res_fd = (bitpos_inc == r_frame_bits);
                            n_bitpos = bitpos_inc;
                            n_adv    = 1'b1;
                            n_wrap   = (col_inc == COL_W'(COLS));
                            n_prod   = PROD_W'(r_stride) * PROD_W'(mul_opnd);
                            if (col_inc == COL_W'(COLS)) begin
                                n_col = '0;
                                n_row = row_inc;
                            end else begin
                                n_col = col_inc;
                            end
                        end else begin
                            n_res_oof = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_ADV: begin
                // fold the step into the offset modulo the store depth, or on a row wrap replace the offset with it
                n_res_rd  = r_res_rd;
                n_res_li  = r_res_li;
                n_res_sa  = r_res_sa;
                n_res_fd  = r_res_fd;
                n_res_oof = r_res_oof;
                if (r_adv) begin
                    n_offset = r_wrap ? f_mod_depth(MW'(r_prod))
                                      : f_mod_depth(MW'(r_offset) + MW'(r_prod));
                end
            end
            ST_RESP: begin
                n_res_rd  = r_res_rd;
                n_res_li  = r_res_li;
                n_res_sa  = r_res_sa;
                n_res_fd  = r_res_fd;
                n_res_oof = r_res_oof;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_offset    <= '0;
            r_bitpos    <= '0;
            r_base      <= '0;
            r_adv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_row    <= n_row;
            r_offset <= n_offset;
            r_bitpos <= n_bitpos;
            r_base   <= n_base;
            r_adv    <= n_adv;
            if (r_state == ST_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req  <= t_req'(i_req_type);
            r_dbit <= i_data_bit;
            r_addr <= i_address;
            r_we   <= i_write_enable;
        end
        r_res_rd  <= n_res_rd;
        r_res_li  <= n_res_li;
        r_res_sa  <= n_res_sa;
        r_res_fd  <= n_res_fd;
        r_res_oof <= n_res_oof;
        r_wrap    <= n_wrap;
        r_prod    <= n_prod;
        if (r_state == ST_RESP && out_free) begin
            r_out_rb  <= r_res_rd & ram_rdata;
            r_out_li  <= r_res_li;
            r_out_sa  <= r_res_sa;
            r_out_fd  <= r_res_fd;
            r_out_oof <= r_res_oof;
        end
    end

    // interleaved bit store
    bi24_ram #(
        .WIDTH (1),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_read_bit      = r_out_rb;
    assign o_linear_index  = r_out_li;
    assign o_store_address = r_out_sa;
    assign o_frame_done    = r_out_fd;
    assign o_out_of_frame  = r_out_oof;

endmodule

/* design/bi24_ram.sv */
// Generic single-port RAM with registered read.
module bi24_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* dv/tb_block_bit_interleaver_24col.sv */
// Self-checking testbench for the 24-column block bit interleaver.
module tb_block_bit_interleaver_24col
    import bi24_pkg::*;
();

    localparam int DEPTH    = 1024;
    localparam int N_RANDOM = 700;

    // One result as the block reports it
    typedef struct packed {
        logic            read_bit;
        logic [FB_W-1:0] linear_index;
        logic [FB_W-1:0] store_address;
        logic            frame_done;
        logic            out_of_frame;
    } t_bit_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_req_type = REQ_NONE;
    logic               i_data_bit = 1'b0;
    logic [FB_W-1:0]    i_address = '0;
    logic               i_write_enable = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    logic               o_read_bit;
    logic [FB_W-1:0]    o_linear_index;
    logic [FB_W-1:0]    o_store_address;
    logic               o_frame_done;
    logic               o_out_of_frame;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_A_W-1:0] i_cfg_index = CFG_FRAME_BITS;
    logic [FB_W-1:0]    i_cfg_data = '0;

    block_bit_interleaver_24col dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the interleaver: store, address generator, registers
    logic            store_bits [DEPTH];
    bit              store_known [DEPTH];
    int              written_addrs [$];
    logic [COL_W-1:0] col_cnt = '0;
    logic [FB_W-1:0] row_cnt = '0;
    logic [FB_W-1:0] addr_offset = '0;
    logic [FB_W-1:0] bit_pos = '0;
    logic [FB_W-1:0] base_addr = '0;
    logic [FB_W-1:0] cfg_frame_bits = 10'd1;
    logic [STR_W-1:0] cfg_stride = 4'd1;
    logic            cfg_deinterleave = 1'b0;

    t_bit_result pending_results [$];
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          requests_sent = 0;
    bit          no_idle = 1'b0;

    function automatic void store_write(logic [FB_W-1:0] a, logic d);
        store_bits[a] = d;
        if (!store_known[a]) begin
            store_known[a] = 1'b1;
            written_addrs.push_back(int'(a));
        end
    endfunction

    // Expected result of one request; advances the shadow state
    function automatic t_bit_result interleave_predict(t_req req, logic dbit,
                                                       logic [FB_W-1:0] addr, logic we);
        t_bit_result res;
        logic [FB_W-1:0] a;
        int unsigned q, r, inc;
        res = '0;
        case (req)
            REQ_START: begin
                base_addr   = addr;
                col_cnt     = '0;
                row_cnt     = '0;
                addr_offset = '0;
                bit_pos     = '0;
                res.store_address = addr;
            end
            REQ_DIRECT: begin
                res.store_address = addr;
                if (we)
                    store_write(addr, dbit);
                else
                    res.read_bit = store_bits[addr];
            end
            REQ_LINEAR: begin
                if (bit_pos >= cfg_frame_bits) begin
                    res.out_of_frame = 1'b1;
                end else begin
                    a = base_addr + addr_offset;
                    res.store_address = a;
                    res.linear_index  = bit_pos;
                    if (cfg_deinterleave)
                        res.read_bit = store_bits[a];
                    else
                        store_write(a, dbit);
                    bit_pos = bit_pos + 1'b1;
                    res.frame_done = (bit_pos == cfg_frame_bits);
                    // column step, row wrap at 24 columns
                    q = cfg_frame_bits / COLS;
                    r = cfg_frame_bits % COLS;
                    if (col_cnt == COLS - 1) begin
                        col_cnt     = '0;
                        row_cnt     = row_cnt + 1'b1;
                        inc         = cfg_stride * row_cnt;
                        addr_offset = inc[FB_W-1:0];
                    end else begin
                        col_cnt     = col_cnt + 1'b1;
                        inc         = cfg_stride * (q + ((col_cnt > r) ? 0 : 1));
                        inc         = inc + addr_offset;
                        addr_offset = inc[FB_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drive one request and wait for its transfer
    task automatic send_req(t_req req, logic dbit, logic [FB_W-1:0] addr, logic we);
        int gap;
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_data_bit     <= dbit;
        i_address      <= addr;
        i_write_enable <= we;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        pending_results.push_back(interleave_predict(req, dbit, addr, we));
        if (req != REQ_NONE)
            requests_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Linear access; on the read side, make sure the target bit was stored first
    task automatic send_linear(logic dbit);
        logic [FB_W-1:0] tgt;
        tgt = base_addr + addr_offset;
        if (cfg_deinterleave && bit_pos < cfg_frame_bits && !store_known[tgt])
            send_req(REQ_DIRECT, 1'($urandom_range(0, 1)), tgt, 1'b1);
        send_req(REQ_LINEAR, dbit, FB_W'($urandom_range(0, DEPTH - 1)),
                 1'($urandom_range(0, 1)));
    endtask

    task automatic send_direct_read();
        if (written_addrs.size() == 0)
            send_req(REQ_DIRECT, 1'($urandom_range(0, 1)),
                     FB_W'($urandom_range(0, DEPTH - 1)), 1'b1);
        else
            send_req(REQ_DIRECT, 1'($urandom_range(0, 1)),
                     FB_W'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]), 1'b0);
    endtask

    task automatic send_noise();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            send_req(REQ_DIRECT, 1'($urandom_range(0, 1)),
                     FB_W'($urandom_range(0, DEPTH - 1)), 1'b1);
        else if (roll < 7)
            send_direct_read();
        else if (roll < 9)
            send_req(REQ_NONE, 1'($urandom_range(0, 1)), FB_W'($urandom_range(0, DEPTH - 1)),
                     1'($urandom_range(0, 1)));
        else
            send_linear(1'($urandom_range(0, 1)));
    endtask

    // Drop valid and wait until every result is back and the block has settled
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register transfer; caller makes sure the block is idle
    task automatic write_reg(t_cfg_idx idx, logic [FB_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            CFG_FRAME_BITS: cfg_frame_bits   = data;
            CFG_STRIDE:     cfg_stride       = data[STR_W-1:0];
            CFG_DIRECTION:  cfg_deinterleave = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [FB_W-1:0] fbits, logic [FB_W-1:0] stride_word,
                             logic [FB_W-1:0] dir_word);
        wait_idle();
        write_reg(CFG_FRAME_BITS, fbits);
        write_reg(CFG_STRIDE, stride_word);
        write_reg(CFG_DIRECTION, dir_word);
    endtask

    // Start, one frame of linear accesses (optional noise, break), then overrun
    task automatic run_frame(int noise_pct, bit broken);
        int n;
        send_req(REQ_START, 1'($urandom_range(0, 1)), FB_W'($urandom_range(0, DEPTH - 1)),
                 1'($urandom_range(0, 1)));
        n = int'(cfg_frame_bits);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise();
            if (broken && i == n / 2) begin
                if ($urandom_range(0, 1)) begin
                    // restart in the middle of the frame
                    send_req(REQ_START, 1'($urandom_range(0, 1)),
                             FB_W'($urandom_range(0, DEPTH - 1)), 1'($urandom_range(0, 1)));
                end else begin
                    // stride change mid-frame
                    wait_idle();
                    write_reg(CFG_STRIDE, FB_W'($urandom_range(0, DEPTH - 1)));
                end
            end
            send_linear(1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(1, 2)) send_linear(1'($urandom_range(0, 1)));
    endtask

    task automatic test_directed();
        no_idle = 1'b1;
        // reset settings: one-bit frame, then overrun
        send_req(REQ_LINEAR, 1'b1, 10'h3FF, 1'b1);
        send_req(REQ_LINEAR, 1'b0, 10'h000, 1'b0);
        send_req(REQ_NONE, 1'b1, 10'h3FF, 1'b1);
        // direct fill and drain at the address extremes
        send_req(REQ_DIRECT, 1'b1, 10'h3FF, 1'b1);
        send_req(REQ_DIRECT, 1'b0, 10'h000, 1'b1);
        send_req(REQ_DIRECT, 1'b1, 10'h2AA, 1'b1);
        send_req(REQ_DIRECT, 1'b0, 10'h155, 1'b1);
        send_req(REQ_DIRECT, 1'b1, 10'h3FF, 1'b0);
        send_req(REQ_DIRECT, 1'b0, 10'h000, 1'b0);
        send_req(REQ_DIRECT, 1'b1, 10'h2AA, 1'b0);
        send_req(REQ_DIRECT, 1'b1, 10'h155, 1'b0);
        // start at the top address, write there
        send_req(REQ_START, 1'b1, 10'h3FF, 1'b1);
        send_linear(1'b0);
        no_idle = 1'b0;
    endtask

    task automatic test_zero_frame_and_readback();
        // empty frame: every linear access is out of frame
        configure(10'd0, 10'h3C1, 10'h3FF);
        write_reg(CFG_UNUSED, 10'h3FF);
        send_linear(1'b1);
        send_req(REQ_START, 1'b0, 10'h000, 1'b0);
        send_linear(1'b0);
        // two-bit de-interleave frame wrapping from the top address to zero
        configure(10'd2, 10'd1, 10'd1);
        send_req(REQ_START, 1'b0, 10'h3FF, 1'b0);
        repeat (3) send_linear(1'b1);
    endtask

    task automatic test_midframe_change();
        configure(10'd30, 10'd2, 10'd0);
        send_req(REQ_START, 1'b0, FB_W'($urandom_range(0, DEPTH - 1)), 1'b0);
        repeat (6) send_linear(1'($urandom_range(0, 1)));
        wait_idle();
        write_reg(CFG_STRIDE, 10'd5);
        write_reg(CFG_FRAME_BITS, 10'd8);
        repeat (4) send_linear(1'($urandom_range(0, 1)));
    endtask

    // Largest frame setting: first rows written, then read back from the same base
    task automatic test_longest_frame();
        logic [FB_W-1:0] base;
        base = FB_W'($urandom_range(0, DEPTH - 1));
        configure(10'd1023, 10'd1, 10'd0);
        no_idle = 1'b1;
        send_req(REQ_START, 1'b0, base, 1'b0);
        repeat (96) send_linear(1'($urandom_range(0, 1)));
        no_idle = 1'b0;
        configure(10'd1023, 10'd1, 10'd1);
        send_req(REQ_START, 1'b1, base, 1'b1);
        repeat (48) send_linear(1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_frames();
        int target, frame_no, roll;
        logic [FB_W-1:0] fbits;
        logic [STR_W-1:0] stride;
        int near_cols [6] = '{23, 24, 25, 47, 48, 49};
        target = requests_sent + N_RANDOM;
        frame_no = 0;
        while (requests_sent < target) begin
            // first frames pin the stride and column extremes
            case (frame_no)
                0: begin fbits = 10'd5;  stride = 4'd0;  end
                1: begin fbits = 10'd60; stride = 4'd15; end
                2: begin fbits = 10'd24; stride = 4'd8;  end
                3: begin fbits = 10'd23; stride = 4'd1;  end
                default: begin
                    roll = $urandom_range(0, 99);
                    if (roll < 5)
                        fbits = 10'd0;
                    else if (roll < 20)
                        fbits = FB_W'(near_cols[$urandom_range(0, 5)]);
                    else
                        fbits = FB_W'($urandom_range(1, 96));
                    if ($urandom_range(0, 99) < 15)
                        stride = ($urandom_range(0, 3) == 0) ? 4'd0
                                                             : STR_W'($urandom_range(9, 15));
                    else
                        stride = STR_W'($urandom_range(1, 8));
                end
            endcase
            configure(fbits, {6'($urandom_range(0, 63)), stride},
                      {9'($urandom_range(0, 511)), 1'($urandom_range(0, 1))});
            no_idle = (frame_no % 4 == 3);
            if ($urandom_range(0, 3) == 0)
                run_frame(30, 1'b1);
            else
                run_frame($urandom_range(0, 10), 1'b0);
            no_idle = 1'b0;
            frame_no++;
        end
    endtask

    // Receiver pacing: runs of ready broken by stalls, none while no_idle is set
    initial begin : sink_pacing
        int len;
        forever begin
            i_out_ready <= 1'b1;
            len = no_idle ? 1 : $urandom_range(1, 12);
            repeat (len) @(posedge i_clk);
            if (!no_idle && $urandom_range(0, 9) < 4) begin
                i_out_ready <= 1'b0;
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                repeat (len) @(posedge i_clk);
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_bit_result exp_res, got_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_res = {o_read_bit, o_linear_index, o_store_address, o_frame_done,
                       o_out_of_frame};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"result %0d with nothing expected:",
                              " rb=%0b li=%0d sa=%0d fd=%0b oof=%0b"},
                             results_seen, got_res.read_bit, got_res.linear_index,
                             got_res.store_address, got_res.frame_done, got_res.out_of_frame);
            end else begin
                exp_res = pending_results.pop_front();
                if (got_res !== exp_res) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d mismatch: exp rb=%0b li=%0d sa=%0d fd=%0b oof=%0b,",
                                  " got rb=%0b li=%0d sa=%0d fd=%0b oof=%0b"},
                                 results_seen, exp_res.read_bit, exp_res.linear_index,
                                 exp_res.store_address, exp_res.frame_done, exp_res.out_of_frame,
                                 got_res.read_bit, got_res.linear_index, got_res.store_address,
                                 got_res.frame_done, got_res.out_of_frame);
                end
            end
            results_seen++;
        end
    end

    // Main sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_zero_frame_and_readback();
        test_midframe_change();
        test_longest_frame();
        test_random_frames();
        wait_idle();
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("** block_bit_interleaver_24col: PASSED **");
        else
            $display("** block_bit_interleaver_24col: FAILED **");
        $finish;
    end

    // Hang guard
    initial begin
        #10_000_000;
        $display("** block_bit_interleaver_24col: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
design/bi24_pkg.sv
design/bi24_ram.sv
design/block_bit_interleaver_24col.sv
dv/tb_block_bit_interleaver_24col.sv
